// File: hdl/tbm_pkg.sv
// Package for the typed byte memory: access modes, result kinds, sequencer states,
// memory request struct and size constants.
// No dependencies.
package tbm_pkg;

    localparam int MEM_DEPTH_DEF = 64;
    localparam int ADDR_W        = 6;
    localparam int SIZE_W        = 7;
    localparam int CNT_W         = 7;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

    typedef enum logic [2:0] {
        M_ST_B,
        M_ST_H,
        M_ST_W,
        M_LD_B,
        M_LD_H,
        M_LD_W,
        M_LD_STR,
        M_ST_CHR
    } t_mode;

    typedef enum logic [1:0] {
        K_VALUE,
        K_CHAR,
        K_END,
        K_VIOL
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_WR,
        S_RD,
        S_RDW,
        S_SRD,
        S_SRDW,
        S_WCH,
        S_WTERM
    } t_state;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } t_mem_req;

    // bytes touched by a scalar access
    function automatic logic [2:0] access_bytes(t_mode m);
        logic [2:0] n;
        unique case (m)
            M_ST_H, M_LD_H: n = 3'd2;
            M_ST_W, M_LD_W: n = 3'd4;
            default:        n = 3'd1;
        endcase
        return n;
    endfunction

endpackage

// File: hdl/tbm_mem.sv
// Byte store with one shared read/write port and registered read data.
// Per-entry valid bits make every byte read as zero after reset or clear.
// Depends on tbm_pkg (request struct).
module tbm_mem #(
    parameter int DEPTH = tbm_pkg::MEM_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_clear,
    input  tbm_pkg::t_mem_req i_req,
    output logic [7:0]        o_rdata
);

    localparam int AW = $clog2(DEPTH);

    logic [7:0]       r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [7:0]       r_rdata;
    logic             r_rvalid;
    logic [AW-1:0]    idx;

    assign idx = i_req.addr[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid <= '0;
        end else if (i_req.we) begin
            r_valid[idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[idx] <= i_req.wdata;
        end
        r_rdata  <= r_mem[idx];
        r_rvalid <= r_valid[idx];
    end

    assign o_rdata = r_rvalid ? r_rdata : 8'h00;

endmodule

// File: hdl/tbm_seq.sv
// Access sequencer: one shared address adder / bounds comparator drives every
// bounds check and every byte access, one byte per step.
// Depends on tbm_pkg.
module tbm_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic [2:0]                  i_mode,
    input  logic [tbm_pkg::ADDR_W-1:0]  i_address,
    input  logic signed [31:0]          i_store_value,
    input  logic [tbm_pkg::ADDR_W-1:0]  i_char_position,
    input  logic [tbm_pkg::ADDR_W-1:0]  i_string_length,
    input  logic [tbm_pkg::SIZE_W-1:0]  i_size,
    output tbm_pkg::t_mem_req           o_req,
    input  logic [7:0]                  i_rdata,
    output logic                        o_valid,
    output logic [1:0]                  o_kind,
    output logic signed [31:0]          o_result_value,
    output logic                        o_last
);
    import tbm_pkg::*;

    t_state             r_state, n_state;
    t_mode              r_mode;
    logic [ADDR_W-1:0]  r_addr;
    logic [31:0]        r_val;
    logic [ADDR_W-1:0]  r_pos;
    logic [ADDR_W-1:0]  r_len;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [31:0]        r_acc, n_acc;
    logic               r_ovalid, n_ovalid;
    t_kind              r_okind, n_okind;
    logic [31:0]        r_oval, n_oval;
    logic               r_olast, n_olast;

    logic [CNT_W-1:0]   off;
    logic [SIZE_W:0]    sum;
    logic               over;
    logic               at_end;
    logic               cnt_last;
    logic               accept;

    assign accept = i_start && (r_state == S_IDLE);

    // shared adder: base address plus a state-selected offset
    always_comb begin
        off = '0;
        unique case (r_state)
            S_CHECK: begin
                if (r_mode == M_LD_STR) begin
                    off = CNT_W'(1);
                end else if (r_mode == M_ST_CHR) begin
                    off = {1'b0, r_len} + CNT_W'(1);
                end else begin
                    off = CNT_W'(access_bytes(r_mode));
                end
            end
            S_WR, S_RD, S_SRD: off = r_cnt;
            S_SRDW:            off = r_cnt + CNT_W'(1);
            S_WCH:             off = {1'b0, r_pos};
            S_WTERM:           off = {1'b0, r_len};
            default:           off = '0;
        endcase
    end

    assign sum      = {2'b00, r_addr} + {1'b0, off};
    assign over     = sum > {1'b0, i_size};
    assign at_end   = sum == {1'b0, i_size};
    assign cnt_last = (r_cnt[2:0] + 3'd1) == access_bytes(r_mode);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_start) n_state = S_CHECK;
            S_CHECK: begin
                if (over) begin
                    n_state = S_IDLE;
                end else begin
                    unique case (r_mode)
                        M_ST_B, M_ST_H, M_ST_W: n_state = S_WR;
                        M_LD_B, M_LD_H, M_LD_W: n_state = S_RD;
                        M_LD_STR:               n_state = S_SRD;
                        M_ST_CHR:               n_state = (r_pos < r_len) ? S_WCH : S_WTERM;
                    endcase
                end
            end
            S_WR:    n_state = cnt_last ? S_IDLE : S_WR;
            S_RD:    n_state = S_RDW;
            S_RDW:   n_state = cnt_last ? S_IDLE : S_RD;
            S_SRD:   n_state = S_SRDW;
            S_SRDW:  n_state = (i_rdata == 8'h00 || at_end) ? S_IDLE : S_SRD;
            S_WCH:   n_state = S_WTERM;
            S_WTERM: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_cnt       = r_cnt;
        n_acc       = r_acc;
        n_ovalid    = 1'b0;
        n_okind     = r_okind;
        n_oval      = r_oval;
        n_olast     = r_olast;
        o_req.we    = 1'b0;
        o_req.addr  = sum[ADDR_W-1:0];
        o_req.wdata = 8'h00;
        unique case (r_state)
            S_IDLE: n_cnt = '0;
            S_CHECK: begin
                // a rejected string reports once, on its first character
                if (over && (r_mode != M_ST_CHR || r_pos == '0)) begin
                    n_ovalid = 1'b1;
                    n_okind  = K_VIOL;
                    n_oval   = '0;
                    n_olast  = 1'b1;
                end
            end
            S_WR: begin
                o_req.we    = 1'b1;
                o_req.wdata = r_val[8*r_cnt[1:0] +: 8];
                n_cnt       = r_cnt + CNT_W'(1);
            end
            S_RD: ;
            S_RDW: begin
                n_acc[8*r_cnt[1:0] +: 8] = i_rdata;
                n_cnt = r_cnt + CNT_W'(1);
                if (cnt_last) begin
                    n_ovalid = 1'b1;
                    n_okind  = K_VALUE;
                    n_olast  = 1'b1;
                    unique case (r_mode)
                        M_LD_B:  n_oval = {{24{n_acc[7]}}, n_acc[7:0]};
                        M_LD_H:  n_oval = {{16{n_acc[15]}}, n_acc[15:0]};
                        default: n_oval = n_acc;
                    endcase
                end
            end
            S_SRD: ;
            S_SRDW: begin
                n_ovalid = 1'b1;
                n_cnt    = r_cnt + CNT_W'(1);
                if (i_rdata == 8'h00) begin
                    n_okind = K_END;
                    n_oval  = '0;
                    n_olast = 1'b1;
                end else begin
                    n_okind = K_CHAR;
                    n_oval  = {24'h000000, i_rdata};
                    n_olast = at_end;
                end
            end
            S_WCH: begin
                o_req.we    = 1'b1;
                o_req.wdata = r_val[7:0];
            end
            S_WTERM: begin
                o_req.we    = 1'b1;
                o_req.wdata = 8'h00;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= t_mode'(i_mode);
            r_addr <= i_address;
            r_val  <= i_store_value;
            r_pos  <= i_char_position;
            r_len  <= i_string_length;
        end
        r_cnt   <= n_cnt;
        r_acc   <= n_acc;
        r_okind <= n_okind;
        r_oval  <= n_oval;
        r_olast <= n_olast;
    end

    assign o_busy         = r_state != S_IDLE;
    assign o_valid        = r_ovalid;
    assign o_kind         = r_okind;
    assign o_result_value = r_oval;
    assign o_last         = r_olast;

    a_accept_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == S_CHECK)
        else $error("accepted item did not enter the bounds check");

    a_over_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK && over) |=> r_state == S_IDLE)
        else $error("out-of-bounds item kept running");

    a_more_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !r_olast) |-> r_state != S_IDLE)
        else $error("non-final result with sequencer idle");

    a_viol_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_okind == K_VIOL) |-> (r_olast && r_oval == '0))
        else $error("violation result malformed");

endmodule

// File: hdl/typed_byte_memory_load_store_top.sv
// Top level of the typed byte memory: size register on the APB port,
// byte store and access sequencer.
// Depends on tbm_pkg, tbm_mem and tbm_seq.
//
// Usage: an item is taken when start is high and busy is low. Results appear on
// o_kind/o_result_value/o_last for one cycle each, flagged by o_valid, in the cycle
// after the step that made them; a final result shows in the first cycle with
// busy low. o_last marks the final result of an item. The receiver cannot stall,
// so results are never held.
// Busy steps, all set by the single byte port of the store and the shared adder:
//   scalar store of n bytes: bounds check, then n byte writes, no result
//   scalar load of n bytes : bounds check, then n byte reads
//   string load of k chars : bounds check, k reads, terminator read as a char
//   string character store : bounds check, char if position < length, terminator
// A failed check ends the item; a byte read issues, then takes registered data.
// mem_size sits at address 0 and reads back; writing it clears the store.
// Reset sets mem_size to 64 and clears all bytes at once through per-byte
// valid flags, so no clearing pass is needed and items are taken right away.
module typed_byte_memory_load_store_top #(
    parameter int MEM_DEPTH = tbm_pkg::MEM_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [2:0]                  i_mode,
    input  logic [tbm_pkg::ADDR_W-1:0]  i_address,
    input  logic signed [31:0]          i_store_value,
    input  logic [tbm_pkg::ADDR_W-1:0]  i_char_position,
    input  logic [tbm_pkg::ADDR_W-1:0]  i_string_length,
    output logic                        o_valid,
    output logic [1:0]                  o_kind,
    output logic signed [31:0]          o_result_value,
    output logic                        o_last,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import tbm_pkg::*;

    logic [SIZE_W-1:0] r_mem_size;
    logic [SIZE_W-1:0] used_size;
    logic              cfg_wr;
    t_mem_req          mem_req;
    logic [7:0]        mem_rdata;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_size <= SIZE_RESET;
        end else if (cfg_wr) begin
            r_mem_size <= pwdata[SIZE_W-1:0];
        end
    end

    assign prdata    = paddr[2] ? 32'h0 : {{(32-SIZE_W){1'b0}}, r_mem_size};
    assign used_size = (r_mem_size > SIZE_W'(MEM_DEPTH)) ? SIZE_W'(MEM_DEPTH) : r_mem_size;

    tbm_mem #(
        .DEPTH (MEM_DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (cfg_wr),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    tbm_seq u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .o_busy          (busy),
        .i_mode          (i_mode),
        .i_address       (i_address),
        .i_store_value   (i_store_value),
        .i_char_position (i_char_position),
        .i_string_length (i_string_length),
        .i_size          (used_size),
        .o_req           (mem_req),
        .i_rdata         (mem_rdata),
        .o_valid         (o_valid),
        .o_kind          (o_kind),
        .o_result_value  (o_result_value),
        .o_last          (o_last)
    );

endmodule

// File: verif/typed_byte_memory_load_store_top_tb.sv
// Self-checking testbench for typed_byte_memory_load_store_top: scalar and string
// accesses are predicted on a shadow copy of the byte store and checked result by result.
// Depends on tbm_pkg and the RTL of the typed byte memory.
module typed_byte_memory_load_store_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tbm_pkg::*;

    localparam int         DEPTH         = 64;
    localparam logic [2:0] MEM_SIZE_ADDR = 3'd0;
    localparam int         DRAIN_LIMIT   = 2000;

    typedef struct {
        t_kind       kind;
        logic [31:0] value;
        logic        last;
    } mem_result_t;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        start           = 1'b0;
    logic [2:0]  i_mode          = 3'd0;
    logic [5:0]  i_address       = 6'd0;
    logic [31:0] i_store_value   = 32'd0;
    logic [5:0]  i_char_position = 6'd0;
    logic [5:0]  i_string_length = 6'd0;
    logic        psel            = 1'b0;
    logic        penable         = 1'b0;
    logic        pwrite          = 1'b0;
    logic [2:0]  paddr           = 3'd0;
    logic [31:0] pwdata          = 32'd0;

    logic        busy;
    logic        o_valid;
    logic [1:0]  o_kind;
    logic [31:0] o_result_value;
    logic        o_last;
    logic [31:0] prdata;
    logic        pready;

    // shadow of the byte store and the size register
    logic [7:0]  shadow_mem [DEPTH];
    logic [6:0]  shadow_size = SIZE_RESET;
    mem_result_t pending_results [$];
    int          error_count = 0;
    int          items_sent  = 0;
    int          gap_pct     = 0;

    always #6 i_clk = ~i_clk;

    typed_byte_memory_load_store_top #(
        .MEM_DEPTH(DEPTH)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_mode         (i_mode),
        .i_address      (i_address),
        .i_store_value  (i_store_value),
        .i_char_position(i_char_position),
        .i_string_length(i_string_length),
        .o_valid        (o_valid),
        .o_kind         (o_kind),
        .o_result_value (o_result_value),
        .o_last         (o_last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    function automatic void push_result(t_kind kind, logic [31:0] value, logic last);
        mem_result_t r;
        r.kind  = kind;
        r.value = value;
        r.last  = last;
        pending_results.push_back(r);
    endfunction

    // Applies one accepted item to the shadow store and queues what it should return.
    function automatic void model_access(t_mode mode, int addr, logic [31:0] value,
                                         int pos, int len);
        int          used;
        int          n;
        logic [31:0] v;
        used = (shadow_size > DEPTH) ? DEPTH : int'(shadow_size);
        n    = 1 << (int'(mode) % 3);
        case (mode)
            M_ST_B, M_ST_H, M_ST_W: begin
                if (addr + n > used) begin
                    push_result(K_VIOL, 32'd0, 1'b1);
                end else begin
                    for (int i = 0; i < n; i++)
                        shadow_mem[addr + i] = value[8*i +: 8];
                end
            end
            M_LD_B, M_LD_H, M_LD_W: begin
                if (addr + n > used) begin
                    push_result(K_VIOL, 32'd0, 1'b1);
                end else begin
                    v = 32'd0;
                    for (int i = 0; i < n; i++)
                        v[8*i +: 8] = shadow_mem[addr + i];
                    if (n == 1 && v[7])
                        v[31:8] = '1;
                    else if (n == 2 && v[15])
                        v[31:16] = '1;
                    push_result(K_VALUE, v, 1'b1);
                end
            end
            M_LD_STR: begin
                if (addr >= used) begin
                    push_result(K_VIOL, 32'd0, 1'b1);
                end else begin
                    for (int i = addr; i < used; i++) begin
                        if (shadow_mem[i] == 8'd0) begin
                            push_result(K_END, 32'd0, 1'b1);
                            break;
                        end
                        push_result(K_CHAR, {24'd0, shadow_mem[i]}, i + 1 == used);
                    end
                end
            end
            default: begin
                // whole string is checked on every char; only position 0 reports
                if (addr + len + 1 > used) begin
                    if (pos == 0)
                        push_result(K_VIOL, 32'd0, 1'b1);
                end else begin
                    if (pos < len)
                        shadow_mem[addr + pos] = value[7:0];
                    shadow_mem[addr + len] = 8'd0;
                end
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        mem_result_t exp_r;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: kind %0d value 0x%08h last %0d",
                       o_kind, o_result_value, o_last);
                error_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (o_kind !== exp_r.kind) begin
                    $error("kind: expected %0d, got %0d", exp_r.kind, o_kind);
                    error_count++;
                end
                if (o_result_value !== exp_r.value) begin
                    $error("result_value: expected 0x%08h, got 0x%08h",
                           exp_r.value, o_result_value);
                    error_count++;
                end
                if (o_last !== exp_r.last) begin
                    $error("last: expected %0d, got %0d", exp_r.last, o_last);
                    error_count++;
                end
            end
        end
    end

    task automatic send_item(t_mode mode, logic [5:0] addr, logic [31:0] value,
                             logic [5:0] pos, logic [5:0] len);
        start           <= 1'b1;
        i_mode          <= mode;
        i_address       <= addr;
        i_store_value   <= value;
        i_char_position <= pos;
        i_string_length <= len;
        do @(posedge i_clk); while (busy);
        model_access(mode, addr, value, pos, len);
        items_sent++;
        if ($urandom_range(0, 99) < gap_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // Drains all expected results; leftovers after the limit count as failures.
    task automatic wait_idle(int settle);
        int waited;
        start <= 1'b0;
        repeat (2) @(posedge i_clk);
        waited = 0;
        while ((pending_results.size() != 0 || busy) && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            error_count++;
            pending_results.delete();
        end
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic config_mem_size(logic [6:0] value);
        logic [31:0] rd;
        wait_idle(4);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MEM_SIZE_ADDR;
        pwdata  <= {25'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        shadow_size = value;
        foreach (shadow_mem[i])
            shadow_mem[i] = 8'd0;
        // read back
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== {25'd0, value}) begin
            $error("mem_size: expected %0d, got %0d", value, rd);
            error_count++;
        end
    endtask

    function automatic logic [5:0] pick_addr(int n, int used);
        int r;
        int a;
        r = $urandom_range(0, 99);
        if (r < 10 || used < n)
            return 6'($urandom_range(0, 63));
        if (r < 30) begin
            a = used - n + $urandom_range(0, 3);
            return (a > 63) ? 6'd63 : 6'(a);
        end
        return 6'($urandom_range(0, used - n));
    endfunction

    task automatic random_string_store(int used);
        int          len;
        int          addr;
        int          skip;
        logic [31:0] value;
        len  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 8);
        addr = (used > len && $urandom_range(0, 9) != 0) ? $urandom_range(0, used - len - 1)
                                                          : $urandom_range(0, 63);
        // now and then a broken sequence: one char may be dropped
        skip = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len) : -1;
        for (int p = 0; p < len; p++) begin
            value = $urandom();
            if ($urandom_range(0, 15) != 0)
                value[7:0] = 8'($urandom_range(1, 255));
            else
                value[7:0] = 8'd0;
            if (p != skip)
                send_item(M_ST_CHR, 6'(addr), value, 6'(p), 6'(len));
        end
        if (len == 0)
            send_item(M_ST_CHR, 6'(addr), $urandom(), 6'd0, 6'd0);
        else if ($urandom_range(0, 3) == 0)
            send_item(M_ST_CHR, 6'(addr), $urandom(), 6'($urandom_range(len, 63)), 6'(len));
        if ($urandom_range(0, 1) == 0)
            send_item(M_LD_STR, 6'(addr), $urandom(), 6'($urandom_range(0, 63)),
                      6'($urandom_range(0, 63)));
    endtask

    task automatic random_traffic(int count);
        int    goal;
        int    used;
        int    pick;
        t_mode mode;
        goal = items_sent + count;
        while (items_sent < goal) begin
            used = (shadow_size > DEPTH) ? DEPTH : int'(shadow_size);
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                send_item(t_mode'($urandom_range(0, 7)), 6'($urandom_range(0, 63)), $urandom(),
                          6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
            end else if (pick < 30) begin
                random_string_store(used);
            end else if (pick < 85) begin
                mode = (pick < 60) ? t_mode'($urandom_range(0, 2)) : t_mode'($urandom_range(3, 5));
                send_item(mode, pick_addr(1 << (int'(mode) % 3), used), $urandom(),
                          6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
            end else begin
                send_item(M_LD_STR, pick_addr(1, used), $urandom(),
                          6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
            end
        end
    endtask

    task automatic test_scalar_access();
        gap_pct = 0;
        // word containing bytes equal to 48
        send_item(M_ST_W, 6'd0, 32'h1230_3430, 6'd0, 6'd0);
        send_item(M_LD_W, 6'd0, 32'd0, 6'd0, 6'd0);
        send_item(M_ST_B, 6'd63, 32'hFFFF_FF80, 6'd63, 6'd63);
        send_item(M_LD_B, 6'd63, 32'd0, 6'd0, 6'd0);
        send_item(M_ST_H, 6'd4, 32'h1234_8001, 6'd0, 6'd0);
        send_item(M_LD_H, 6'd4, 32'd0, 6'd0, 6'd0);
        send_item(M_LD_B, 6'd5, 32'd0, 6'd0, 6'd0);
        send_item(M_ST_W, 6'd60, 32'h7FFF_FFFF, 6'd0, 6'd0);
        send_item(M_LD_W, 6'd60, 32'd0, 6'd0, 6'd0);
        send_item(M_LD_B, 6'd63, 32'd0, 6'd0, 6'd0);
        // runs past the end
        send_item(M_ST_W, 6'd61, 32'hDEAD_BEEF, 6'd0, 6'd0);
        send_item(M_LD_H, 6'd63, 32'd0, 6'd0, 6'd0);
        send_item(M_ST_W, 6'd8, 32'h8000_0000, 6'd0, 6'd0);
        send_item(M_LD_W, 6'd8, 32'd0, 6'd0, 6'd0);
    endtask

    task automatic test_string_access();
        send_item(M_ST_CHR, 6'd16, 32'h0000_0061, 6'd0, 6'd3);
        send_item(M_ST_CHR, 6'd16, 32'hFFFF_FF30, 6'd1, 6'd3);
        send_item(M_ST_CHR, 6'd16, 32'h0000_007A, 6'd2, 6'd3);
        send_item(M_ST_CHR, 6'd16, 32'h0000_0055, 6'd5, 6'd3);
        send_item(M_LD_STR, 6'd16, 32'd0, 6'd0, 6'd0);
        // string running into the end of memory: no end marker
        send_item(M_ST_H, 6'd62, 32'h0000_4142, 6'd0, 6'd0);
        send_item(M_LD_STR, 6'd62, 32'd0, 6'd0, 6'd0);
        // terminator only, at the last byte
        send_item(M_ST_CHR, 6'd63, 32'h0000_0058, 6'd0, 6'd0);
        send_item(M_LD_STR, 6'd63, 32'd0, 6'd0, 6'd0);
        // rejected string: one violation for the whole string
        send_item(M_ST_CHR, 6'd60, 32'h0000_0078, 6'd0, 6'd10);
        send_item(M_ST_CHR, 6'd60, 32'h0000_0079, 6'd1, 6'd10);
        send_item(M_ST_CHR, 6'd0, 32'hFFFF_FFFF, 6'd63, 6'd63);
        send_item(M_LD_STR, 6'd0, 32'd0, 6'd0, 6'd0);
    endtask

    task automatic test_mem_size_settings();
        gap_pct = 0;
        config_mem_size(7'd0);
        send_item(M_ST_B, 6'd0, 32'h0000_0011, 6'd0, 6'd0);
        send_item(M_LD_STR, 6'd0, 32'd0, 6'd0, 6'd0);
        send_item(M_ST_CHR, 6'd0, 32'h0000_0041, 6'd0, 6'd0);
        random_traffic(6);
        config_mem_size(7'd1);
        send_item(M_ST_B, 6'd0, 32'h0000_0041, 6'd0, 6'd0);
        send_item(M_LD_STR, 6'd0, 32'd0, 6'd0, 6'd0);
        send_item(M_LD_B, 6'd1, 32'd0, 6'd0, 6'd0);
        send_item(M_ST_CHR, 6'd0, 32'h0000_0042, 6'd0, 6'd0);
        send_item(M_LD_B, 6'd0, 32'd0, 6'd0, 6'd0);
        random_traffic(6);
        config_mem_size(7'd4);
        random_traffic(10);
        // above the depth acts as the full depth
        config_mem_size(7'd127);
        send_item(M_ST_W, 6'd60, 32'h8182_8384, 6'd0, 6'd0);
        send_item(M_LD_W, 6'd60, 32'd0, 6'd0, 6'd0);
        random_traffic(8);
        config_mem_size(7'd37);
        send_item(M_LD_STR, 6'd40, 32'd0, 6'd0, 6'd0);
        random_traffic(10);
    endtask

    task automatic test_random_traffic();
        config_mem_size(7'd64);
        gap_pct = 0;
        random_traffic(70);
        config_mem_size(7'($urandom_range(8, 64)));
        gap_pct = 50;
        random_traffic(70);
        config_mem_size(7'd64);
        gap_pct = 37;
        random_traffic(70);
        gap_pct = 0;
        random_traffic(50);
    endtask

    initial begin
        foreach (shadow_mem[i])
            shadow_mem[i] = 8'd0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_scalar_access();
        test_string_access();
        test_mem_size_settings();
        test_random_traffic();
        wait_idle(40);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// File: files.f
hdl/tbm_pkg.sv
hdl/tbm_mem.sv
hdl/tbm_seq.sv
hdl/typed_byte_memory_load_store_top.sv
verif/typed_byte_memory_load_store_top_tb.sv
